// ----- hdl/gnl_pkg.sv -----
package gnl_pkg;

    localparam int TEXT_ADDR_BITS = 16;

    localparam logic [3:0] KIND_IDENT   = 4'd0;
    localparam logic [3:0] KIND_EQ      = 4'd1;
    localparam logic [3:0] KIND_STAR    = 4'd2;
    localparam logic [3:0] KIND_DOT     = 4'd3;
    localparam logic [3:0] KIND_PLUS    = 4'd4;
    localparam logic [3:0] KIND_PIPE    = 4'd5;
    localparam logic [3:0] KIND_QUEST   = 4'd6;
    localparam logic [3:0] KIND_BANG    = 4'd7;
    localparam logic [3:0] KIND_HASH    = 4'd8;
    localparam logic [3:0] KIND_OPEN    = 4'd9;
    localparam logic [3:0] KIND_CLOSE   = 4'd10;
    localparam logic [3:0] KIND_NEWLINE = 4'd11;
    localparam logic [3:0] KIND_RANGE   = 4'd12;
    localparam logic [3:0] KIND_STRING  = 4'd13;
    localparam logic [3:0] KIND_EOF     = 4'd14;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_STRING = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [3:0]                token_kind;
        logic [TEXT_ADDR_BITS-1:0] start_offset;
        logic [TEXT_ADDR_BITS-1:0] token_length;
        logic [15:0]               start_line;
        logic [15:0]               start_column;
        logic [1:0]                error_code;
        logic                      last_of_run;
    } out_item_t;

endpackage

// ----- hdl/grammar_notation_lexer.sv -----
// A completing byte is captured in the input register; its tokens are then written to the
// token group queue and offered from there. Throughput: one text byte per cycle while the
// queue has room; one token per cycle while token_ready is high, each in its own transfer.
// A four-entry queue of per-byte token groups sets how far the text side may run ahead.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the halt after an
// unclosed literal and restarts counting at offset 0, line 1, column 1.
module grammar_notation_lexer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  gnl_pkg::in_item_t  text_item,
    output logic               token_valid,
    input  logic               token_ready,
    output gnl_pkg::out_item_t token_item
);
    import gnl_pkg::*;

    localparam int GRP_DEPTH = 4;
    localparam int GRP_PTR_BITS = $clog2(GRP_DEPTH);
    localparam int GRP_CNT_BITS = $clog2(GRP_DEPTH + 2);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [15:0] SAT_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_STRING, M_STRING_ESC, M_RANGE, M_HALTED
    } mode_t;

    typedef struct packed {
        out_item_t [2:0] tok;
        logic [1:0]      cnt;
    } grp_t;

    function automatic out_item_t mk(input logic [3:0] kind,
                                     input logic [TEXT_ADDR_BITS-1:0] off,
                                     input logic [TEXT_ADDR_BITS-1:0] len,
                                     input logic [15:0] line, input logic [15:0] col,
                                     input logic [1:0] err);
        out_item_t r;
        r.token_kind   = kind;
        r.start_offset = off;
        r.token_length = len;
        r.start_line   = line;
        r.start_column = col;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_tail(input logic [7:0] b);
        return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_MINUS || b == CH_UNDER;
    endfunction

    function automatic logic [4:0] punct(input logic [7:0] b);
        // Bit 4 flags a punctuation mark, bits 3:0 carry its kind.
        case (b)
            8'h3D:   return {1'b1, KIND_EQ};
            8'h2A:   return {1'b1, KIND_STAR};
            8'h2E:   return {1'b1, KIND_DOT};
            8'h2B:   return {1'b1, KIND_PLUS};
            8'h7C:   return {1'b1, KIND_PIPE};
            8'h3F:   return {1'b1, KIND_QUEST};
            8'h21:   return {1'b1, KIND_BANG};
            8'h23:   return {1'b1, KIND_HASH};
            8'h28:   return {1'b1, KIND_OPEN};
            8'h29:   return {1'b1, KIND_CLOSE};
            default: return {1'b0, KIND_IDENT};
        endcase
    endfunction

    // Input register
    logic     stg_v_reg;
    in_item_t stg_reg;

    // Lexer state
    mode_t                     mode_reg, mode_next;
    logic                      qdbl_reg, qdbl_next;
    logic [TEXT_ADDR_BITS-1:0] off_reg, off_next;
    logic [15:0]               line_reg, line_next;
    logic [15:0]               col_reg, col_next;
    logic [TEXT_ADDR_BITS-1:0] tb_off_reg, tb_off_next;
    logic [15:0]               tb_line_reg, tb_line_next;
    logic [15:0]               tb_col_reg, tb_col_next;
    logic                      lwn_reg, lwn_next;

    // Token group queue
    grp_t                    grp_mem [GRP_DEPTH];
    logic [GRP_PTR_BITS-1:0] wptr_reg, rptr_reg;
    logic [GRP_CNT_BITS-1:0] gcnt_reg;
    logic [1:0]              sub_reg;

    out_item_t [2:0] res;
    logic [1:0]      nres;
    logic            push, pop;
    grp_t            head;

    assign text_ready = (gcnt_reg + GRP_CNT_BITS'(stg_v_reg)) < GRP_CNT_BITS'(GRP_DEPTH);

    always_comb
    begin
        logic [7:0] b;
        logic       is_end;
        logic       do_idle;
        logic [4:0] pk;

        b        = stg_reg.text_byte;
        is_end   = stg_reg.end_of_text || b == CH_NUL;
        pk       = punct(b);
        do_idle  = 1'b0;

        mode_next    = mode_reg;
        qdbl_next    = qdbl_reg;
        off_next     = off_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        tb_off_next  = tb_off_reg;
        tb_line_next = tb_line_reg;
        tb_col_next  = tb_col_reg;
        lwn_next     = lwn_reg;
        res          = '0;
        nres         = 2'd0;

        if (stg_v_reg && mode_reg != M_HALTED)
        begin
            if (is_end)
            begin
                case (mode_reg)
                    M_STRING, M_STRING_ESC:
                    begin
                        res[nres] = mk(KIND_IDENT, off_reg, '0, line_reg, col_reg, ERR_STRING);
                        nres = nres + 2'd1;
                        mode_next = M_HALTED;
                    end
                    M_RANGE:
                    begin
                        res[nres] = mk(KIND_IDENT, off_reg, '0, line_reg, col_reg, ERR_RANGE);
                        nres = nres + 2'd1;
                        mode_next = M_HALTED;
                    end
                    M_IDENT:
                    begin
                        res[nres] = mk(KIND_IDENT, tb_off_reg, off_reg - tb_off_reg,
                                       tb_line_reg, tb_col_reg, ERR_NONE);
                        nres = nres + 2'd1;
                        lwn_next = 1'b0;
                    end
                    M_COMMENT:
                    begin
                        res[nres] = mk(KIND_NEWLINE, off_reg, '0, line_reg, col_reg, ERR_NONE);
                        nres = nres + 2'd1;
                        lwn_next = 1'b1;
                    end
                    default: ;
                endcase
                if (mode_next != M_HALTED)
                begin
                    if (!lwn_next)
                    begin
                        res[nres] = mk(KIND_NEWLINE, off_reg, '0, line_reg, col_reg, ERR_NONE);
                        nres = nres + 2'd1;
                    end
                    res[nres] = mk(KIND_EOF, off_reg, '0, line_reg, col_reg, ERR_NONE);
                    nres = nres + 2'd1;
                    // The text is over: everything restarts for the next one.
                    mode_next    = M_IDLE;
                    qdbl_next    = 1'b0;
                    off_next     = '0;
                    line_next    = 16'd1;
                    col_next     = 16'd1;
                    tb_off_next  = '0;
                    tb_line_next = 16'd1;
                    tb_col_next  = 16'd1;
                    lwn_next     = 1'b0;
                end
            end
            else
            begin
                case (mode_reg)
                    M_SLASH:
                    begin
                        if (b == CH_SLASH)
                        begin
                            mode_next = M_COMMENT;
                        end
                        else
                        begin
                            mode_next = M_IDLE;
                            do_idle = 1'b1;
                        end
                    end
                    M_COMMENT:
                    begin
                        // The newline that ends a comment is also a newline token itself.
                        if (b == CH_NL)
                        begin
                            res[nres] = mk(KIND_NEWLINE, off_reg, '0, line_reg, col_reg,
                                           ERR_NONE);
                            nres = nres + 2'd1;
                            lwn_next = 1'b1;
                            mode_next = M_IDLE;
                            do_idle = 1'b1;
                        end
                    end
                    M_IDENT:
                    begin
                        if (!is_tail(b))
                        begin
                            res[nres] = mk(KIND_IDENT, tb_off_reg, off_reg - tb_off_reg,
                                           tb_line_reg, tb_col_reg, ERR_NONE);
                            nres = nres + 2'd1;
                            lwn_next = 1'b0;
                            mode_next = M_IDLE;
                            do_idle = 1'b1;
                        end
                    end
                    M_STRING:
                    begin
                        if (b == (qdbl_reg ? CH_DQUOTE : CH_SQUOTE))
                        begin
                            res[nres] = mk(KIND_STRING, tb_off_reg,
                                           off_reg + TEXT_ADDR_BITS'(1) - tb_off_reg,
                                           tb_line_reg, tb_col_reg, ERR_NONE);
                            nres = nres + 2'd1;
                            lwn_next = 1'b0;
                            mode_next = M_IDLE;
                        end
                        else if (b == CH_BSLASH)
                        begin
                            mode_next = M_STRING_ESC;
                        end
                        else if (b == CH_NL)
                        begin
                            res[nres] = mk(KIND_IDENT, off_reg, '0, line_reg, col_reg,
                                           ERR_STRING);
                            nres = nres + 2'd1;
                            mode_next = M_HALTED;
                        end
                    end
                    M_STRING_ESC:
                    begin
                        mode_next = M_STRING;
                    end
                    M_RANGE:
                    begin
                        if (b == CH_RBRACK)
                        begin
                            res[nres] = mk(KIND_RANGE, tb_off_reg,
                                           off_reg + TEXT_ADDR_BITS'(1) - tb_off_reg,
                                           tb_line_reg, tb_col_reg, ERR_NONE);
                            nres = nres + 2'd1;
                            lwn_next = 1'b0;
                            mode_next = M_IDLE;
                        end
                        else if (b == CH_NL)
                        begin
                            res[nres] = mk(KIND_IDENT, off_reg, '0, line_reg, col_reg,
                                           ERR_RANGE);
                            nres = nres + 2'd1;
                            mode_next = M_HALTED;
                        end
                    end
                    default:
                    begin
                        do_idle = 1'b1;
                    end
                endcase

                if (do_idle)
                begin
                    if (b == CH_SLASH)
                    begin
                        mode_next = M_SLASH;
                    end
                    else if (b == CH_NL)
                    begin
                        res[nres] = mk(KIND_NEWLINE, off_reg, '0, line_reg, col_reg, ERR_NONE);
                        nres = nres + 2'd1;
                        lwn_next = 1'b1;
                    end
                    else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                    begin
                        mode_next = M_IDLE;
                    end
                    else if (is_alpha(b))
                    begin
                        tb_off_next  = off_reg;
                        tb_line_next = line_reg;
                        tb_col_next  = col_reg;
                        mode_next    = M_IDENT;
                    end
                    else if (pk[4])
                    begin
                        res[nres] = mk(pk[3:0], off_reg, TEXT_ADDR_BITS'(1), line_reg, col_reg,
                                       ERR_NONE);
                        nres = nres + 2'd1;
                        lwn_next = 1'b0;
                    end
                    else if (b == CH_SQUOTE || b == CH_DQUOTE)
                    begin
                        tb_off_next  = off_reg;
                        tb_line_next = line_reg;
                        tb_col_next  = col_reg;
                        qdbl_next    = (b == CH_DQUOTE);
                        mode_next    = M_STRING;
                    end
                    else if (b == CH_LBRACK)
                    begin
                        tb_off_next  = off_reg;
                        tb_line_next = line_reg;
                        tb_col_next  = col_reg;
                        mode_next    = M_RANGE;
                    end
                end

                if (mode_next != M_HALTED)
                begin
                    off_next = off_reg + TEXT_ADDR_BITS'(1);
                    if (b == CH_NL)
                    begin
                        line_next = (line_reg == SAT_MAX) ? line_reg : line_reg + 16'd1;
                        col_next  = 16'd1;
                    end
                    else
                    begin
                        col_next = (col_reg == SAT_MAX) ? col_reg : col_reg + 16'd1;
                    end
                end
            end
        end
    end

    assign push        = nres != 2'd0;
    assign head        = grp_mem[rptr_reg];
    assign token_valid = gcnt_reg != '0;
    assign pop         = token_valid && token_ready && (sub_reg == head.cnt - 2'd1);

    always_comb
    begin
        token_item             = head.tok[sub_reg];
        token_item.last_of_run = (sub_reg == head.cnt - 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_v_reg   <= 1'b0;
            mode_reg    <= M_IDLE;
            qdbl_reg    <= 1'b0;
            off_reg     <= '0;
            line_reg    <= 16'd1;
            col_reg     <= 16'd1;
            tb_off_reg  <= '0;
            tb_line_reg <= 16'd1;
            tb_col_reg  <= 16'd1;
            lwn_reg     <= 1'b0;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            gcnt_reg    <= '0;
            sub_reg     <= 2'd0;
        end
        else
        begin
            stg_v_reg   <= text_valid && text_ready;
            mode_reg    <= mode_next;
            qdbl_reg    <= qdbl_next;
            off_reg     <= off_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            tb_off_reg  <= tb_off_next;
            tb_line_reg <= tb_line_next;
            tb_col_reg  <= tb_col_next;
            lwn_reg     <= lwn_next;
            if (push)
            begin
                wptr_reg <= wptr_reg + GRP_PTR_BITS'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + GRP_PTR_BITS'(1);
                sub_reg  <= 2'd0;
            end
            else if (token_valid && token_ready)
            begin
                sub_reg <= sub_reg + 2'd1;
            end
            gcnt_reg <= gcnt_reg + GRP_CNT_BITS'(push) - GRP_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            stg_reg <= text_item;
        end
        if (push)
        begin
            grp_mem[wptr_reg] <= '{tok: res, cnt: nres};
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gcnt_reg <= GRP_CNT_BITS'(GRP_DEPTH))
        else $error("token group queue overflow");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_HALTED |-> !push && mode_next == M_HALTED)
        else $error("tokens produced after an unclosed literal");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.error_code != ERR_NONE |-> token_item.last_of_run)
        else $error("error result is not the only result of its byte");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.token_kind == KIND_EOF |-> token_item.last_of_run)
        else $error("eof token is not the last result of its byte");

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    import gnl_pkg::*;

    localparam int  TEXT_ITEMS    = 430;
    localparam int  CALM_ITEMS    = 60;
    localparam int  STUCK_LIMIT   = 500;
    localparam int  SETTLE_CYCLES = 20;
    localparam int  MAX_REPORTS   = 40;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = "\n";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_SQUOTE = "'";
    localparam logic [7:0] CH_DQUOTE = "\"";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_RBRACK = "]";
    localparam logic [3:0] NO_MARK   = 4'hF;

    typedef enum logic [2:0] {
        LX_IDLE, LX_SLASH, LX_COMMENT, LX_NAME, LX_STRING, LX_ESCAPE, LX_RANGE, LX_HALTED
    } lex_mode_e;

    typedef struct {
        in_item_t item;
        bit       drain_first;
        bit       calm;
    } text_entry_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      text_valid = 1'b0;
    logic      text_ready;
    in_item_t  text_item = '0;
    logic      token_valid;
    logic      token_ready = 1'b1;
    out_item_t token_item;

    grammar_notation_lexer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_item   (text_item),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_item  (token_item)
    );

    text_entry_t text_q[$];
    out_item_t   exp_tokens[$];
    out_item_t   step_tokens[$];

    bit mark_drain;
    bit mark_calm;
    bit calm;
    int send_gap;
    int stall_left;
    int stuck_cycles;
    int err_count;
    int n_items;
    int n_tokens;
    int n_texts;
    int n_faults;

    // Lexer state as the predictor sees it.
    lex_mode_e   lx_mode;
    logic        lx_dquote;
    logic        lx_last_nl;
    logic [15:0] lx_off;
    logic [15:0] lx_line;
    logic [15:0] lx_col;
    logic [15:0] tk_off;
    logic [15:0] tk_line;
    logic [15:0] tk_col;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_name_char(logic [7:0] b);
        return is_letter(b) || (b >= "0" && b <= "9") || b == "-" || b == "_";
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [3:0] mark_kind(logic [7:0] b);
        case (b)
            "=": return KIND_EQ;
            "*": return KIND_STAR;
            ".": return KIND_DOT;
            "+": return KIND_PLUS;
            "|": return KIND_PIPE;
            "?": return KIND_QUEST;
            "!": return KIND_BANG;
            "#": return KIND_HASH;
            "(": return KIND_OPEN;
            ")": return KIND_CLOSE;
            default: return NO_MARK;
        endcase
    endfunction

    task automatic lex_clear();
        lx_mode    = LX_IDLE;
        lx_dquote  = 1'b0;
        lx_last_nl = 1'b0;
        lx_off     = 16'd0;
        lx_line    = 16'd1;
        lx_col     = 16'd1;
        tk_off     = 16'd0;
        tk_line    = 16'd1;
        tk_col     = 16'd1;
    endtask

    task automatic add_token(logic [3:0] kind, logic [15:0] off, logic [15:0] len,
                             logic [15:0] line, logic [15:0] col, logic [1:0] err);
        out_item_t t;
        t.token_kind   = kind;
        t.start_offset = off;
        t.token_length = len;
        t.start_line   = line;
        t.start_column = col;
        t.error_code   = err;
        t.last_of_run  = 1'b0;
        step_tokens.push_back(t);
        if (err == ERR_NONE)
            lx_last_nl = (kind == KIND_NEWLINE);
    endtask

    task automatic add_here(logic [3:0] kind, logic [15:0] len);
        add_token(kind, lx_off, len, lx_line, lx_col, ERR_NONE);
    endtask

    // The length wraps with the offset counter.
    task automatic add_begun(logic [3:0] kind, logic [15:0] end_off);
        add_token(kind, tk_off, end_off - tk_off, tk_line, tk_col, ERR_NONE);
    endtask

    task automatic mark_token_start();
        tk_off  = lx_off;
        tk_line = lx_line;
        tk_col  = lx_col;
    endtask

    task automatic lex_fail(logic [1:0] code);
        add_token(KIND_IDENT, lx_off, 16'd0, lx_line, lx_col, code);
        lx_mode = LX_HALTED;
    endtask

    task automatic lex_idle(logic [7:0] b);
        logic [3:0] mk;
        mk = mark_kind(b);
        if (b == CH_SLASH)
        begin
            lx_mode = LX_SLASH;
        end
        else if (b == CH_NL)
        begin
            add_here(KIND_NEWLINE, 16'd0);
        end
        else if (!is_blank(b))
        begin
            if (is_letter(b))
            begin
                mark_token_start();
                lx_mode = LX_NAME;
            end
            else if (mk != NO_MARK)
            begin
                add_here(mk, 16'd1);
            end
            else if (b == CH_SQUOTE || b == CH_DQUOTE)
            begin
                mark_token_start();
                lx_dquote = (b == CH_DQUOTE);
                lx_mode = LX_STRING;
            end
            else if (b == CH_LBRACK)
            begin
                mark_token_start();
                lx_mode = LX_RANGE;
            end
        end
    endtask

    task automatic predict_tokens(in_item_t it);
        logic [7:0] b;
        logic       text_done;
        b = it.text_byte;
        text_done = it.end_of_text || b == CH_NUL;
        step_tokens.delete();
        if (lx_mode != LX_HALTED)
        begin
            if (text_done)
            begin
                case (lx_mode)
                    LX_STRING, LX_ESCAPE: lex_fail(ERR_STRING);
                    LX_RANGE:             lex_fail(ERR_RANGE);
                    LX_NAME:              add_begun(KIND_IDENT, lx_off);
                    LX_COMMENT:           add_here(KIND_NEWLINE, 16'd0);
                    default: ;
                endcase
                if (lx_mode != LX_HALTED)
                begin
                    if (!lx_last_nl)
                        add_here(KIND_NEWLINE, 16'd0);
                    add_here(KIND_EOF, 16'd0);
                    lex_clear();
                end
            end
            else
            begin
                case (lx_mode)
                    LX_SLASH:
                        if (b == CH_SLASH)
                        begin
                            lx_mode = LX_COMMENT;
                        end
                        else
                        begin
                            lx_mode = LX_IDLE;
                            lex_idle(b);
                        end
                    // A newline ending a comment yields its own token and then the
                    // ordinary newline token, both at the same position.
                    LX_COMMENT:
                        if (b == CH_NL)
                        begin
                            add_here(KIND_NEWLINE, 16'd0);
                            lx_mode = LX_IDLE;
                            lex_idle(b);
                        end
                    LX_NAME:
                        if (!is_name_char(b))
                        begin
                            add_begun(KIND_IDENT, lx_off);
                            lx_mode = LX_IDLE;
                            lex_idle(b);
                        end
                    LX_STRING:
                        if (b == (lx_dquote ? CH_DQUOTE : CH_SQUOTE))
                        begin
                            add_begun(KIND_STRING, lx_off + 16'd1);
                            lx_mode = LX_IDLE;
                        end
                        else if (b == CH_BSLASH)
                        begin
                            lx_mode = LX_ESCAPE;
                        end
                        else if (b == CH_NL)
                        begin
                            lex_fail(ERR_STRING);
                        end
                    LX_ESCAPE:
                        lx_mode = LX_STRING;
                    LX_RANGE:
                        if (b == CH_RBRACK)
                        begin
                            add_begun(KIND_RANGE, lx_off + 16'd1);
                            lx_mode = LX_IDLE;
                        end
                        else if (b == CH_NL)
                        begin
                            lex_fail(ERR_RANGE);
                        end
                    default:
                        lex_idle(b);
                endcase
                if (lx_mode != LX_HALTED)
                begin
                    lx_off = lx_off + 16'd1;
                    if (b == CH_NL)
                    begin
                        if (lx_line != 16'hFFFF)
                            lx_line = lx_line + 16'd1;
                        lx_col = 16'd1;
                    end
                    else if (lx_col != 16'hFFFF)
                    begin
                        lx_col = lx_col + 16'd1;
                    end
                end
            end
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
            foreach (step_tokens[i])
                exp_tokens.push_back(step_tokens[i]);
        end
    endtask

    task automatic report_mismatch(string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("MISMATCH token %0d: %s", n_tokens, what);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Stimulus helpers.
    task automatic push_text(logic [7:0] b, logic eot = 1'b0);
        text_entry_t e;
        e.item.text_byte   = b;
        e.item.end_of_text = eot;
        e.drain_first      = mark_drain;
        e.calm             = mark_calm;
        mark_drain = 1'b0;
        mark_calm  = 1'b0;
        text_q.push_back(e);
    endtask

    // Random nonzero byte other than the four given.
    function automatic logic [7:0] pick_byte(logic [7:0] x0, logic [7:0] x1,
                                             logic [7:0] x2, logic [7:0] x3);
        logic [7:0] r;
        do
            r = 8'($urandom_range(1, 255));
        while (r == x0 || r == x1 || r == x2 || r == x3);
        return r;
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1))
            return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_mark();
        logic [7:0] marks [10] = '{"=", "*", ".", "+", "|", "?", "!", "#", "(", ")"};
        return marks[$urandom_range(0, 9)];
    endfunction

    task automatic push_string();
        logic [7:0] q;
        int         n;
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        n = $urandom_range(0, 4);
        push_text(q);
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                push_text(CH_BSLASH);
                push_text(8'($urandom_range(1, 255)));
            end
            else
            begin
                push_text(pick_byte(CH_NL, q, CH_BSLASH, CH_BSLASH));
            end
        end
        push_text(q);
    endtask

    // Every lexeme leaves the lexer outside any literal, so no error can occur
    // before the closing part of the run.
    task automatic push_lexeme();
        int pick;
        int n;
        logic [7:0] blanks [5] = '{" ", 8'd9, 8'd11, 8'd12, 8'd13};
        pick = $urandom_range(0, 19);
        if (pick <= 3)
        begin
            push_text(pick_letter());
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0: push_text(pick_letter());
                    1: push_text(8'("0" + $urandom_range(0, 9)));
                    2: push_text("-");
                    default: push_text("_");
                endcase
            end
        end
        else if (pick <= 6)
        begin
            push_text(pick_mark());
        end
        else if (pick <= 8)
        begin
            push_text(blanks[$urandom_range(0, 4)]);
        end
        else if (pick <= 10)
        begin
            push_text(CH_NL);
        end
        else if (pick <= 12)
        begin
            push_string();
        end
        else if (pick == 13)
        begin
            push_text(CH_LBRACK);
            n = $urandom_range(0, 5);
            repeat (n)
                push_text(pick_byte(CH_NL, CH_RBRACK, CH_RBRACK, CH_RBRACK));
            push_text(CH_RBRACK);
        end
        else if (pick == 14)
        begin
            push_text(CH_SLASH);
            push_text(CH_SLASH);
            n = $urandom_range(0, 5);
            repeat (n)
                push_text(pick_byte(CH_NL, CH_NL, CH_NL, CH_NL));
            if ($urandom_range(0, 3) == 0)
                push_text(8'($urandom_range(0, 255)), 1'b1);
            else
                push_text(CH_NL);
        end
        else if (pick == 15)
        begin
            push_text(CH_SLASH);
            push_text(pick_byte(CH_SQUOTE, CH_DQUOTE, CH_LBRACK, CH_SLASH));
        end
        else if (pick <= 17)
        begin
            push_text(pick_byte(CH_SQUOTE, CH_DQUOTE, CH_LBRACK, CH_SLASH));
        end
        else if (pick == 18)
        begin
            if ($urandom_range(0, 1))
                push_text(8'($urandom_range(0, 255)), 1'b1);
            else
                push_text(CH_NUL);
        end
        else
        begin
            push_text(pick_letter());
            push_text(pick_mark());
        end
    endtask

    // Text side: bursts of idle cycles between transfers, none once calm.
    always @(posedge clk)
    begin
        text_entry_t next_entry;
        if (!rst_n)
        begin
            text_valid <= 1'b0;
        end
        else if (!text_valid || text_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                text_valid <= 1'b0;
            end
            else if (text_q.size() == 0)
            begin
                text_valid <= 1'b0;
            end
            else if (text_q[0].drain_first && (text_valid || exp_tokens.size() != 0))
            begin
                text_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                send_gap <= $urandom_range(0, 18);
                text_valid <= 1'b0;
            end
            else
            begin
                next_entry = text_q.pop_front();
                text_item <= next_entry.item;
                text_valid <= 1'b1;
                if (next_entry.calm)
                    calm <= 1'b1;
            end
        end
    end

    // Token side: random stall bursts, none once calm.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            token_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            token_ready <= 1'b0;
        end
        else
        begin
            token_ready <= 1'b1;
        end
    end

    // Input transfers are predicted before token transfers are checked.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (text_valid && text_ready)
            begin
                n_items++;
                predict_tokens(text_item);
            end
            if (token_valid && token_ready)
            begin
                got = token_item;
                n_tokens++;
                if (got.error_code != ERR_NONE)
                    n_faults++;
                else if (got.token_kind == KIND_EOF)
                    n_texts++;
                if (exp_tokens.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected token, kind %0d offset %0d",
                                              got.token_kind, got.start_offset));
                end
                else
                begin
                    want = exp_tokens.pop_front();
                    check_field("token_kind", 16'(got.token_kind), 16'(want.token_kind));
                    check_field("start_offset", got.start_offset, want.start_offset);
                    check_field("token_length", got.token_length, want.token_length);
                    check_field("start_line", got.start_line, want.start_line);
                    check_field("start_column", got.start_column, want.start_column);
                    check_field("error_code", 16'(got.error_code), 16'(want.error_code));
                    check_field("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
                end
            end
            if ((text_valid && text_ready) || (token_valid && token_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("TIMEOUT after %0d cycles without a transfer", stuck_cycles);
                $display("tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] opener;
        lex_clear();

        // Directed text: identifier characters, every mark, a lone slash, a comment,
        // a string with an escaped quote, a range holding a high byte, then the end.
        push_text("A");
        push_text("_");
        push_text("9");
        push_text("-");
        push_text("=");
        push_text("*");
        push_text(".");
        push_text("+");
        push_text("|");
        push_text("?");
        push_text("!");
        push_text("#");
        push_text("(");
        push_text(")");
        push_text(CH_SLASH);
        push_text(" ");
        push_text(CH_SLASH);
        push_text(CH_SLASH);
        push_text(CH_NL);
        push_text(CH_DQUOTE);
        push_text(CH_BSLASH);
        push_text(CH_DQUOTE);
        push_text(CH_DQUOTE);
        push_text(CH_LBRACK);
        push_text(8'h80);
        push_text(CH_RBRACK);
        push_text(8'hFF, 1'b1);

        // Random texts; the sender waits for all tokens before the first and
        // again half way through, and stops idling for the last stretch.
        mark_drain = 1'b1;
        while (text_q.size() < TEXT_ITEMS / 2)
            push_lexeme();
        mark_drain = 1'b1;
        while (text_q.size() < TEXT_ITEMS - CALM_ITEMS)
            push_lexeme();
        mark_calm = 1'b1;
        while (text_q.size() < TEXT_ITEMS)
            push_lexeme();

        // An unclosed literal halts the block; what follows must be ignored.
        opener = $urandom_range(0, 1) ? CH_LBRACK
                 : ($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
        push_text(pick_letter());
        push_text(opener);
        push_text(pick_letter());
        case ($urandom_range(0, 2))
            0: push_text(CH_NL);
            1: push_text(CH_NUL);
            default: push_text(8'($urandom_range(0, 255)), 1'b1);
        endcase
        push_text(pick_letter());
        push_text("=");
        push_text(CH_NL);
        push_text(8'($urandom_range(0, 255)), 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (text_q.size() != 0 || text_valid || exp_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (exp_tokens.size() != 0)
            report_mismatch($sformatf("%0d expected tokens never arrived", exp_tokens.size()));

        $display("Lexed %0d text bytes into %0d tokens over %0d complete texts.",
                 n_items, n_tokens, n_texts);
        $display("Covered idle bursts on both sides, drain pauses and %0d unclosed-literal halt.",
                 n_faults);
        if (err_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
